[rtl/core/dprd_pkg.sv]
// Shared types and constants for the dosage/probability record decoder.
`default_nettype none

package dprd_pkg;

  localparam int WORD_W = 16;
  localparam int DOSE_W = 15;
  localparam int PROB_W = 18;
  localparam int SUBJ_W = 12;
  localparam int NSUB_W = 13;

  localparam logic [NSUB_W-1:0] NSUB_RESET   = 13'd4096;
  localparam logic [DOSE_W-1:0] DOSE_MISSING = 15'd20000;
  localparam logic [DOSE_W-1:0] DOSE_HALF    = 15'd10000;
  localparam logic [PROB_W-1:0] PROB_FULL    = 18'd20000;

  typedef struct packed {
    logic [SUBJ_W-1:0] subject;
    logic [DOSE_W-1:0] dose;
  } queue_entry_t;

  typedef enum logic [1:0] {
    EXTRA_FIRST,
    EXTRA_PROB0,
    EXTRA_PROB2
  } extra_step_t;

endpackage

`default_nettype wire

[rtl/core/dprd_queue.sv]
// Storage for queued subjects: one write port, one registered read port with write bypass.
`default_nettype none

module dprd_queue #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     wr_en,
  input  wire [AW-1:0]            wr_addr,
  input  dprd_pkg::queue_entry_t  wr_data,
  input  wire [AW-1:0]            rd_addr,
  output dprd_pkg::queue_entry_t  rd_data
);

  dprd_pkg::queue_entry_t mem [DEPTH];
  dprd_pkg::queue_entry_t rd_q;
  dprd_pkg::queue_entry_t byp_data;
  logic                   byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    byp_data <= wr_data;
  end

  // a write to the address being read returns the new entry next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

`default_nettype wire

[rtl/core/dosage_probability_record_decoder_top.sv]
// Top level of the dosage/probability record decoder.
// Usage:
//   Words of the record stream enter on in_valid/in_ready/word, one transfer
//   per word. Results leave on out_valid/out_ready with subject_index,
//   missing, dosage, prob0, prob1, prob2 and record_last; record_last marks
//   the final result of each record.
//   cfg_we/cfg_wdata write num_subjects (primary words per record); write it
//   only while the block is idle. Reset value is 4096.
// Timing:
//   A word goes into an input register, is decoded from there and its
//   result (if any) is written to the result register as the word advances.
//   One word per cycle is sustained while out_ready stays high; the decode
//   is a single pass of small adders plus one queue push or pop, with queued
//   subjects in a MAX_SUBJECTS-deep memory read through a registered port.
// Reset:
//   Synchronous rst clears the phase, counters, queue pointers and both
//   valid flags; queue contents are not cleared.
// Stalls:
//   While the result register holds an untaken result, the input register
//   still takes one word; in_ready drops only when both are occupied.
`default_nettype none

module dosage_probability_record_decoder_top #(
  parameter int MAX_SUBJECTS = 4096
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire  [12:0]        cfg_wdata,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [15:0]        word,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [11:0]        subject_index,
  output logic               missing,
  output logic [14:0]        dosage,
  output logic signed [17:0] prob0,
  output logic signed [17:0] prob1,
  output logic signed [17:0] prob2,
  output logic               record_last
);

  localparam int AW = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
  localparam int CW = $clog2(MAX_SUBJECTS + 1);
  localparam int WW = (CW > dprd_pkg::NSUB_W) ? CW : dprd_pkg::NSUB_W;
  localparam logic [AW-1:0] PTR_LAST = AW'(MAX_SUBJECTS - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SUBJECTS);
  localparam logic [WW-1:0] ACT_MAX  = WW'(MAX_SUBJECTS);

  // configuration
  logic [dprd_pkg::NSUB_W-1:0] num_subjects;

  // input stage
  logic                        s1_valid;
  logic [dprd_pkg::WORD_W-1:0] s1_word;
  logic                        advance;

  // decode state
  logic                        in_extra, in_extra_next;
  logic [CW-1:0]               primary_seen, primary_seen_next;
  logic [AW-1:0]               head, head_next;
  logic [AW-1:0]               tail, tail_next;
  logic [CW-1:0]               count, count_next;
  dprd_pkg::extra_step_t       extra_step, extra_step_next;
  logic [dprd_pkg::DOSE_W-1:0] held_prob1, held_prob1_next;
  logic [dprd_pkg::WORD_W-1:0] held_prob0, held_prob0_next;

  // queue port
  logic                        push;
  dprd_pkg::queue_entry_t      push_entry;
  dprd_pkg::queue_entry_t      head_entry;

  // result of the current word
  logic                        produced;
  logic [dprd_pkg::SUBJ_W-1:0] r_subject;
  logic                        r_missing;
  logic [dprd_pkg::DOSE_W-1:0] r_dose;
  logic [dprd_pkg::PROB_W-1:0] r_p0, r_p1, r_p2;
  logic                        r_last;

  // helpers
  logic [dprd_pkg::DOSE_W-1:0] low;
  logic                        flag;
  logic [WW-1:0]               n_ext;
  logic [WW-1:0]               active;
  logic [CW-1:0]               seen_inc;
  logic                        ends;
  logic [CW-1:0]               count_pushed;
  logic [CW-1:0]               count_popped;
  logic [AW-1:0]               head_inc;
  logic [AW-1:0]               tail_inc;
  logic [dprd_pkg::DOSE_W-1:0] dose_over;
  logic [dprd_pkg::PROB_W-1:0] p2_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_subjects <= dprd_pkg::NSUB_RESET;
    end else if (cfg_we) begin
      num_subjects <= cfg_wdata;
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= word;
    end
  end

  assign low   = s1_word[dprd_pkg::DOSE_W-1:0];
  assign flag  = s1_word[dprd_pkg::WORD_W-1];
  assign n_ext = WW'(num_subjects);

  // clamp the subject count to 1..MAX_SUBJECTS
  always_comb begin
    if (num_subjects == '0) begin
      active = WW'(1);
    end else if (n_ext > ACT_MAX) begin
      active = ACT_MAX;
    end else begin
      active = n_ext;
    end
  end

  assign seen_inc     = primary_seen + CW'(1);
  assign ends         = WW'(seen_inc) >= active;
  assign count_pushed = count + CW'(1);
  assign count_popped = count - CW'(1);
  assign head_inc     = (head == PTR_LAST) ? '0 : head + AW'(1);
  assign tail_inc     = (tail == PTR_LAST) ? '0 : tail + AW'(1);
  assign dose_over    = low - dprd_pkg::DOSE_HALF;
  assign p2_high      = {2'b00, dose_over, 1'b0};

  assign push_entry.subject = dprd_pkg::SUBJ_W'(primary_seen);
  assign push_entry.dose    = low;

  always_comb begin
    in_extra_next     = in_extra;
    primary_seen_next = primary_seen;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    extra_step_next   = extra_step;
    held_prob1_next   = held_prob1;
    held_prob0_next   = held_prob0;
    push              = 1'b0;
    produced          = 1'b0;
    r_subject         = dprd_pkg::SUBJ_W'(primary_seen);
    r_missing         = 1'b0;
    r_dose            = low;
    r_p0              = '0;
    r_p1              = '0;
    r_p2              = '0;
    r_last            = 1'b0;

    if (advance) begin
      if (!in_extra) begin
        produced          = 1'b1;
        primary_seen_next = seen_inc;
        if (low > dprd_pkg::DOSE_MISSING) begin
          r_missing = 1'b1;
          r_dose    = '0;
        end else if (flag) begin
          produced = 1'b0;
          if (count < CNT_MAX) begin
            push       = 1'b1;
            tail_next  = tail_inc;
            count_next = count_pushed;
          end
        end else if (low > dprd_pkg::DOSE_HALF) begin
          r_p2 = p2_high;
          r_p1 = dprd_pkg::PROB_FULL - p2_high;
        end else begin
          r_p1 = {2'b00, low, 1'b0};
          r_p0 = dprd_pkg::PROB_FULL - {2'b00, low, 1'b0};
        end
        if (ends) begin
          primary_seen_next = '0;
          if (count_next != '0) begin
            in_extra_next   = 1'b1;
            extra_step_next = dprd_pkg::EXTRA_FIRST;
          end
        end
        r_last = ends && (count_next == '0);
      end else if (count == '0) begin
        in_extra_next   = 1'b0;
        extra_step_next = dprd_pkg::EXTRA_FIRST;
      end else begin
        r_subject = head_entry.subject;
        r_dose    = head_entry.dose;
        unique case (extra_step)
          dprd_pkg::EXTRA_PROB0: begin
            held_prob0_next = s1_word;
            extra_step_next = dprd_pkg::EXTRA_PROB2;
          end
          dprd_pkg::EXTRA_PROB2: begin
            produced        = 1'b1;
            r_p1            = {2'b00, held_prob1, 1'b0};
            r_p0            = {1'b0, held_prob0, 1'b0};
            r_p2            = {1'b0, s1_word, 1'b0};
            extra_step_next = dprd_pkg::EXTRA_FIRST;
          end
          dprd_pkg::EXTRA_FIRST: begin
            if (flag) begin
              held_prob1_next = low;
              extra_step_next = dprd_pkg::EXTRA_PROB0;
            end else begin
              produced = 1'b1;
              r_p1     = {2'b00, low, 1'b0};
              r_p2     = {3'b000, head_entry.dose} - {3'b000, low};
              r_p0     = dprd_pkg::PROB_FULL - {3'b000, head_entry.dose}
                         - {3'b000, low};
            end
          end
          default: begin
            extra_step_next = dprd_pkg::EXTRA_FIRST;
          end
        endcase
        // pop the head subject with its result
        if (produced) begin
          head_next  = head_inc;
          count_next = count_popped;
          if (count_popped == '0) begin
            in_extra_next = 1'b0;
            r_last        = 1'b1;
          end
        end
      end
    end
  end

  dprd_queue #(
    .DEPTH (MAX_SUBJECTS),
    .AW    (AW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (push_entry),
    .rd_addr (head_next),
    .rd_data (head_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_extra     <= 1'b0;
      primary_seen <= '0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      extra_step   <= dprd_pkg::EXTRA_FIRST;
      held_prob1   <= '0;
      held_prob0   <= '0;
    end else begin
      in_extra     <= in_extra_next;
      primary_seen <= primary_seen_next;
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
      extra_step   <= extra_step_next;
      held_prob1   <= held_prob1_next;
      held_prob0   <= held_prob0_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produced) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produced) begin
      subject_index <= r_subject;
      missing       <= r_missing;
      dosage        <= r_dose;
      prob0         <= r_p0;
      prob1         <= r_p1;
      prob2         <= r_p2;
      record_last   <= r_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("queue count above depth");

  a_extra_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_extra |-> count != '0)
    else $error("extra phase with empty queue");

  a_primary_step: assert property (@(posedge clk) disable iff (rst)
    !in_extra |-> extra_step == dprd_pkg::EXTRA_FIRST)
    else $error("extra step left pending in primary phase");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("queue pointers differ while empty");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && missing |->
      dosage == '0 && prob0 == '0 && prob1 == '0 && prob2 == '0)
    else $error("missing result carries nonzero values");

endmodule

`default_nettype wire

[bench/dosage_probability_record_checker.sv]
`timescale 1ns / 100ps
// Checker for the record decoder: tracks the decode of every word and compares each result.
module dosage_probability_record_checker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [dprd_pkg::NSUB_W-1:0]        cfg_wdata,
  input  wire                               in_valid,
  input  wire                               in_ready,
  input  wire [dprd_pkg::WORD_W-1:0]        word,
  input  wire                               out_valid,
  input  wire                               out_ready,
  input  wire [dprd_pkg::SUBJ_W-1:0]        subject_index,
  input  wire                               missing,
  input  wire [dprd_pkg::DOSE_W-1:0]        dosage,
  input  wire signed [dprd_pkg::PROB_W-1:0] prob0,
  input  wire signed [dprd_pkg::PROB_W-1:0] prob1,
  input  wire signed [dprd_pkg::PROB_W-1:0] prob2,
  input  wire                               record_last,
  output int                                mismatches,
  output int                                pending,
  output int                                results_checked,
  output int                                records_closed
);

  localparam int QUEUE_DEPTH   = 4096;
  localparam int FULL_SCALE    = dprd_pkg::PROB_FULL;
  localparam int HALF_DOSE     = dprd_pkg::DOSE_HALF;
  localparam int MISSING_ABOVE = dprd_pkg::DOSE_MISSING;

  typedef struct {
    logic [dprd_pkg::SUBJ_W-1:0]        subject;
    logic                               miss;
    logic [dprd_pkg::DOSE_W-1:0]        dose;
    logic signed [dprd_pkg::PROB_W-1:0] p0;
    logic signed [dprd_pkg::PROB_W-1:0] p1;
    logic signed [dprd_pkg::PROB_W-1:0] p2;
    logic                               last;
  } subject_result_t;

  logic [dprd_pkg::NSUB_W-1:0] subject_count;
  bit                          extra_phase;
  int                          primary_pos;
  dprd_pkg::queue_entry_t      held_subjects [QUEUE_DEPTH];
  int                          held_head;
  int                          held_tail;
  int                          held_count;
  dprd_pkg::extra_step_t       extra_step;
  logic [dprd_pkg::DOSE_W-1:0] held_p1;
  logic [dprd_pkg::WORD_W-1:0] held_p0;
  subject_result_t             expected_results [$];

  task automatic push_result(input logic [dprd_pkg::SUBJ_W-1:0] subj, input logic miss,
                             input int dose, input int p0, input int p1, input int p2,
                             input logic last);
    subject_result_t r;
    r.subject = subj;
    r.miss    = miss;
    r.dose    = dose[dprd_pkg::DOSE_W-1:0];
    r.p0      = p0[dprd_pkg::PROB_W-1:0];
    r.p1      = p1[dprd_pkg::PROB_W-1:0];
    r.p2      = p2[dprd_pkg::PROB_W-1:0];
    r.last    = last;
    expected_results.push_back(r);
  endtask

  task automatic decode_word(input logic [dprd_pkg::WORD_W-1:0] w);
    int d, a, b, p0, p1, p2, limit;
    logic [dprd_pkg::SUBJ_W-1:0] subj;
    dprd_pkg::queue_entry_t e;
    bit ends;
    d = w[dprd_pkg::DOSE_W-1:0];
    p0 = 0;
    p1 = 0;
    p2 = 0;
    if (!extra_phase) begin
      subj = primary_pos[dprd_pkg::SUBJ_W-1:0];
      primary_pos++;
      limit = (subject_count == 0) ? 1 :
              (subject_count > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(subject_count);
      ends = primary_pos >= limit;
      if (d > MISSING_ABOVE) begin
        // missing: nothing queued, even with the flag set
      end else if (w[dprd_pkg::WORD_W-1]) begin
        if (held_count < QUEUE_DEPTH) begin
          held_subjects[held_tail] = '{subject: subj, dose: w[dprd_pkg::DOSE_W-1:0]};
          held_tail = (held_tail + 1) % QUEUE_DEPTH;
          held_count++;
        end
      end else if (d > HALF_DOSE) begin
        p2 = 2 * (d - HALF_DOSE);
        p1 = FULL_SCALE - p2;
      end else begin
        p1 = 2 * d;
        p0 = FULL_SCALE - p1;
      end
      if (ends) begin
        primary_pos = 0;
        if (held_count > 0) begin
          extra_phase = 1'b1;
          extra_step  = dprd_pkg::EXTRA_FIRST;
        end
      end
      if (d > MISSING_ABOVE)
        push_result(subj, 1'b1, 0, 0, 0, 0, ends && held_count == 0);
      else if (!w[dprd_pkg::WORD_W-1])
        push_result(subj, 1'b0, d, p0, p1, p2, ends && held_count == 0);
    end else if (held_count == 0) begin
      extra_phase = 1'b0;
      extra_step  = dprd_pkg::EXTRA_FIRST;
    end else if (extra_step == dprd_pkg::EXTRA_PROB0) begin
      held_p0    = w;
      extra_step = dprd_pkg::EXTRA_PROB2;
    end else if (extra_step == dprd_pkg::EXTRA_FIRST && w[dprd_pkg::WORD_W-1]) begin
      held_p1    = w[dprd_pkg::DOSE_W-1:0];
      extra_step = dprd_pkg::EXTRA_PROB0;
    end else begin
      e = held_subjects[held_head];
      held_head = (held_head + 1) % QUEUE_DEPTH;
      held_count--;
      a = e.dose;
      if (extra_step == dprd_pkg::EXTRA_PROB2) begin
        b  = held_p1;
        p1 = 2 * b;
        b  = held_p0;
        p0 = 2 * b;
        b  = w;
        p2 = 2 * b;
      end else begin
        // derived pair, either may go negative
        p1 = 2 * d;
        p2 = a - d;
        p0 = FULL_SCALE - a - d;
      end
      extra_step = dprd_pkg::EXTRA_FIRST;
      if (held_count == 0)
        extra_phase = 1'b0;
      push_result(e.subject, 1'b0, a, p0, p1, p2, held_count == 0);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_proc
    subject_result_t r;
    if (rst) begin
      subject_count = dprd_pkg::NSUB_RESET;
      extra_phase   = 1'b0;
      primary_pos   = 0;
      held_head     = 0;
      held_tail     = 0;
      held_count    = 0;
      extra_step    = dprd_pkg::EXTRA_FIRST;
      held_p1       = '0;
      held_p0       = '0;
      expected_results.delete();
    end else begin
      if (cfg_we)
        subject_count = cfg_wdata;
      // predict before comparing so a same-edge result still finds its entry
      if (in_valid && in_ready)
        decode_word(word);
      if (out_valid && out_ready) begin
        results_checked++;
        if (record_last)
          records_closed++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual subject %0d",
                   $time, subject_index);
        end else begin
          r = expected_results.pop_front();
          check_field("subject_index", r.subject, subject_index);
          check_field("missing", r.miss, missing);
          check_field("dosage", r.dose, dosage);
          check_field("prob0", r.p0, prob0);
          check_field("prob1", r.p1, prob1);
          check_field("prob2", r.p2, prob2);
          check_field("record_last", r.last, record_last);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

[bench/dosage_probability_record_decoder_top_test.sv]
`timescale 1ns / 100ps
// Testbench top for the record decoder: drives words and subject counts, gives the verdict.
module dosage_probability_record_decoder_top_test;

  localparam int CONFIG_SETTLE = 4;
  localparam int END_SETTLE    = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 1625;
  localparam logic [dprd_pkg::DOSE_W-1:0] EDGE_DOSES [9] = '{
    15'd0, 15'd1, 15'd9999, 15'd10000, 15'd10001, 15'd19999, 15'd20000, 15'd20001, 15'd32767
  };

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_SQUARE
  } ready_pattern_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic [dprd_pkg::NSUB_W-1:0] cfg_wdata = '0;
  logic                        in_valid  = 1'b0;
  logic [dprd_pkg::WORD_W-1:0] word      = '0;
  logic                        out_ready = 1'b0;

  wire                               in_ready;
  wire                               out_valid;
  wire [dprd_pkg::SUBJ_W-1:0]        subject_index;
  wire                               missing;
  wire [dprd_pkg::DOSE_W-1:0]        dosage;
  wire signed [dprd_pkg::PROB_W-1:0] prob0;
  wire signed [dprd_pkg::PROB_W-1:0] prob1;
  wire signed [dprd_pkg::PROB_W-1:0] prob2;
  wire                               record_last;

  int mismatches;
  int pending;
  int results_checked;
  int records_closed;
  int burst_left       = 0;
  int words_sent       = 0;
  int settings_written = 0;
  int idle_cycles      = 0;

  ready_pattern_t ready_mode      = READY_ALWAYS;
  int             ready_mode_left = 0;
  logic [2:0]     ready_phase     = '0;

  dosage_probability_record_decoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .word          (word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .subject_index (subject_index),
    .missing       (missing),
    .dosage        (dosage),
    .prob0         (prob0),
    .prob1         (prob1),
    .prob2         (prob2),
    .record_last   (record_last)
  );

  dosage_probability_record_checker watch (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .word            (word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .subject_index   (subject_index),
    .missing         (missing),
    .dosage          (dosage),
    .prob0           (prob0),
    .prob1           (prob1),
    .prob2           (prob2),
    .record_last     (record_last),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .records_closed  (records_closed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switch at random between four stall patterns.
  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      <= ready_pattern_t'($urandom_range(0, 3));
      ready_mode_left <= $urandom_range(8, 64);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= ready_phase[2];
    endcase
    ready_phase <= ready_phase + 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("dosage_probability_record_decoder_top_test failed");
    $finish;
  end

  function automatic logic [dprd_pkg::DOSE_W-1:0] pick_low();
    logic [dprd_pkg::DOSE_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = EDGE_DOSES[$urandom_range(0, 8)];
      1:       v = dprd_pkg::DOSE_W'($urandom_range(20001, 32767));
      2, 3:    v = dprd_pkg::DOSE_W'($urandom_range(0, 10000));
      4, 5:    v = dprd_pkg::DOSE_W'($urandom_range(10001, 20000));
      default: v = dprd_pkg::DOSE_W'($urandom_range(0, 20000));
    endcase
    return v;
  endfunction

  function automatic logic [dprd_pkg::WORD_W-1:0] pick_word();
    logic [dprd_pkg::WORD_W-1:0] v;
    if ($urandom_range(0, 15) == 0)
      v = dprd_pkg::WORD_W'($urandom);
    else
      v = {($urandom_range(0, 2) == 0), pick_low()};
    return v;
  endfunction

  // Hold each word until its transfer; open a random gap between bursts.
  task automatic send_word(input logic [dprd_pkg::WORD_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    word     <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    words_sent++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_subject_count(input logic [dprd_pkg::NSUB_W-1:0] n);
    wait_drained(CONFIG_SETTLE);
    cfg_wdata <= n;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  initial begin
    int phase_len;
    int random_sent;
    logic [dprd_pkg::NSUB_W-1:0] count_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // One subject per record (zero acts as one): dosage edges, missing, both extra forms.
    set_subject_count(13'd0);
    send_word(16'h0000);
    send_word(16'h2710);
    send_word(16'h2711);
    send_word(16'h4E20);
    send_word(16'h4E21);
    send_word(16'hFFFF);
    send_word(16'h7FFF);
    send_word(16'h9B58);
    send_word(16'h7FFF);
    send_word(16'hCE20);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'hFFFF);

    // Several queued subjects drained in order, negative derived values.
    set_subject_count(13'd4);
    send_word(16'h8000);
    send_word(16'hCE20);
    send_word(16'h1234);
    send_word(16'hA710);
    send_word(16'h8000);
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(16'h4E20);

    // Shrink the count mid-record: the next primary word closes it.
    set_subject_count(13'd3);
    send_word(16'h0001);
    send_word(16'h4E1F);
    set_subject_count(13'd1);
    send_word(16'h0005);

    // Random phases; a phase may end mid-record.
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 15))
        0:       count_val = 13'd0;
        1:       count_val = 13'd1;
        2:       count_val = 13'd4096;
        3:       count_val = dprd_pkg::NSUB_W'($urandom_range(4097, 8191));
        4, 5:    count_val = dprd_pkg::NSUB_W'($urandom_range(17, 300));
        default: count_val = dprd_pkg::NSUB_W'($urandom_range(2, 16));
      endcase
      set_subject_count(count_val);
      phase_len = $urandom_range(10, 150);
      repeat (phase_len) begin
        send_word(pick_word());
        random_sent++;
      end
    end

    wait_drained(END_SETTLE);
    $display("Drove %0d words across %0d subject-count settings, zero and oversize counts included.",
             words_sent, settings_written);
    $display("Checked %0d results, %0d records closed, %0d mismatches.",
             results_checked, records_closed, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("dosage_probability_record_decoder_top_test passed");
    else
      $display("dosage_probability_record_decoder_top_test failed");
    $finish;
  end

endmodule
